/* hw/rtl/tme_pkg.sv */
package tme_pkg;

    localparam int TapeDepth = 32768;
    localparam int TapeAw    = $clog2(TapeDepth);
    localparam int PcW       = 16;

    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_SET     = 4'd1,
        CMD_ADD_OFF = 4'd2,
        CMD_SET_OFF = 4'd3,
        CMD_SHIFT   = 4'd4,
        CMD_MAC     = 4'd5,
        CMD_SEEK    = 4'd6,
        CMD_JZ      = 4'd7,
        CMD_JNZ     = 4'd8,
        CMD_OUT     = 4'd9,
        CMD_IN      = 4'd10,
        CMD_END     = 4'd11
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_OFF,
        ST_WAIT_OFF,
        ST_RD_DP,
        ST_WAIT_DP,
        ST_EXEC,
        ST_SEEK_RD,
        ST_SEEK_CHK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [16:0] arg_a;
        logic [15:0] arg_b;
        logic [7:0]  in_byte;
    } t_item;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        halted;
        logic        seek_stuck;
    } t_result;

    // tape port request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [TapeAw-1:0] rd_addr;
        logic              wr_en;
        logic [TapeAw-1:0] wr_addr;
        logic [7:0]        wr_data;
    } t_tape_req;

endpackage

/* hw/rtl/tme_if.sv */
interface tme_in_if;
    logic           valid;
    logic           ready;
    tme_pkg::t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tme_out_if;
    logic             valid;
    logic             ready;
    tme_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tme_tape.sv */
module tme_tape (
    input  logic                      i_clk,
    input  tme_pkg::t_tape_req        i_req,
    output logic [7:0]                o_rd_data
);
    logic [7:0] r_mem [tme_pkg::TapeDepth];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end
endmodule

/* hw/rtl/tme_seq.sv */
module tme_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tme_in_if.sink             s_in,
    tme_out_if.source          m_out,
    output tme_pkg::t_tape_req o_req,
    input  logic [7:0]         i_rd_data
);
    localparam int Aw = tme_pkg::TapeAw;

    tme_pkg::t_state  r_state, n_state;
    tme_pkg::t_item   r_item;
    logic [Aw-1:0]    r_dp, n_dp;
    logic [15:0]      r_pc, n_pc;
    logic             r_halt, n_halt;
    logic [7:0]       r_off_val;
    logic [Aw-1:0]    r_addr, n_addr;
    logic [Aw:0]      r_cnt, n_cnt;
    logic [Aw-1:0]    r_clr;
    tme_pkg::t_result r_res, n_res;
    logic             r_res_valid;
    logic             r_mul_en;
    logic [7:0]       r_prod;

    logic [Aw-1:0] w_off_addr, w_step, w_next_seek;
    logic [7:0]    w_a8;
    logic [15:0]   w_pc_inc;
    logic          w_last_clr;
    tme_pkg::t_cmd w_cmd;

    assign w_cmd      = tme_pkg::t_cmd'(r_item.cmd);
    assign w_a8       = r_item.arg_a[7:0];
    assign w_off_addr = r_dp + r_item.arg_b[Aw-1:0];
    assign w_step     = r_item.arg_a[Aw-1:0];
    assign w_next_seek = r_addr + w_step;
    assign w_pc_inc   = r_pc + 16'd1;
    assign w_last_clr = (r_clr == {Aw{1'b1}});

    assign s_in.ready  = (r_state == tme_pkg::ST_IDLE) && !r_res_valid;
    assign m_out.valid = r_res_valid;
    assign m_out.data  = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tme_pkg::ST_CLEAR:    if (w_last_clr) n_state = tme_pkg::ST_IDLE;
            tme_pkg::ST_IDLE: begin
                if (s_in.valid && s_in.ready) begin
                    if (r_halt) begin
                        n_state = tme_pkg::ST_RESULT;
                    end else begin
                        case (tme_pkg::t_cmd'(s_in.data.cmd))
                            tme_pkg::CMD_ADD_OFF, tme_pkg::CMD_SET_OFF, tme_pkg::CMD_MAC:
                                n_state = tme_pkg::ST_RD_OFF;
                            tme_pkg::CMD_SEEK: n_state = tme_pkg::ST_SEEK_RD;
                            default:           n_state = tme_pkg::ST_RD_DP;
                        endcase
                    end
                end
            end
            tme_pkg::ST_RD_OFF:   n_state = tme_pkg::ST_WAIT_OFF;
            tme_pkg::ST_WAIT_OFF: n_state = (w_cmd == tme_pkg::CMD_MAC) ?
                                            tme_pkg::ST_RD_DP : tme_pkg::ST_EXEC;
            tme_pkg::ST_RD_DP:    n_state = tme_pkg::ST_WAIT_DP;
            tme_pkg::ST_WAIT_DP:  n_state = tme_pkg::ST_EXEC;
            tme_pkg::ST_EXEC:     n_state = tme_pkg::ST_RESULT;
            tme_pkg::ST_SEEK_RD:  n_state = tme_pkg::ST_SEEK_CHK;
            tme_pkg::ST_SEEK_CHK: begin
                if (i_rd_data == 8'd0 || r_cnt == tme_pkg::TapeDepth[Aw:0] - 1'b1) begin
                    n_state = tme_pkg::ST_RESULT;
                end else begin
                    n_state = tme_pkg::ST_SEEK_RD;
                end
            end
            tme_pkg::ST_RESULT:   n_state = tme_pkg::ST_IDLE;
            default:              n_state = tme_pkg::ST_IDLE;
        endcase
    end

    // datapath and tape requests
    always_comb begin
        n_dp   = r_dp;
        n_pc   = r_pc;
        n_halt = r_halt;
        n_addr = r_addr;
        n_cnt  = r_cnt;
        n_res  = r_res;
        o_req  = '0;
        case (r_state)
            tme_pkg::ST_CLEAR: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = r_clr;
            end
            tme_pkg::ST_IDLE: begin
                n_cnt = '0;
                n_addr = r_dp;
                // hold the pending result beat until a new item is taken
                if (s_in.valid && s_in.ready) begin
                    n_res = '0;
                    n_res.next_pc = r_pc;
                    n_res.halted  = r_halt;
                end
            end
            tme_pkg::ST_RD_OFF: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = w_off_addr;
            end
            tme_pkg::ST_RD_DP: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = r_dp;
            end
            tme_pkg::ST_EXEC: begin
                n_pc = w_pc_inc;
                o_req.wr_addr = r_dp;
                case (w_cmd)
                    tme_pkg::CMD_ADD: begin
                        o_req.wr_en = 1'b1;
                        o_req.wr_data = i_rd_data + w_a8;
                    end
                    tme_pkg::CMD_SET: begin
                        o_req.wr_en = 1'b1;
                        o_req.wr_data = w_a8;
                    end
                    tme_pkg::CMD_ADD_OFF: begin
                        o_req.wr_en = 1'b1;
                        o_req.wr_addr = w_off_addr;
                        o_req.wr_data = r_off_val + w_a8;
                    end
                    tme_pkg::CMD_SET_OFF: begin
                        o_req.wr_en = 1'b1;
                        o_req.wr_addr = w_off_addr;
                        o_req.wr_data = w_a8;
                    end
                    tme_pkg::CMD_SHIFT: n_dp = r_dp + w_step;
                    tme_pkg::CMD_MAC: begin
                        o_req.wr_en = 1'b1;
                        o_req.wr_data = i_rd_data + r_prod;
                    end
                    tme_pkg::CMD_JZ:  if (i_rd_data == 8'd0) n_pc = r_item.arg_a[15:0];
                    tme_pkg::CMD_JNZ: if (i_rd_data != 8'd0) n_pc = r_item.arg_a[15:0];
                    tme_pkg::CMD_OUT: begin
                        n_res.out_valid = 1'b1;
                        n_res.out_byte  = i_rd_data;
                    end
                    tme_pkg::CMD_IN: begin
                        o_req.wr_en = 1'b1;
                        o_req.wr_data = r_item.in_byte;
                    end
                    tme_pkg::CMD_END: begin
                        n_pc   = r_pc;
                        n_halt = 1'b1;
                    end
                    default: ;
                endcase
                n_res.next_pc = n_pc;
                n_res.halted  = n_halt;
            end
            tme_pkg::ST_SEEK_RD: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = r_addr;
            end
            tme_pkg::ST_SEEK_CHK: begin
                if (i_rd_data == 8'd0) begin
                    n_dp = r_addr;
                    n_pc = w_pc_inc;
                end else if (r_cnt == tme_pkg::TapeDepth[Aw:0] - 1'b1) begin
                    n_res.seek_stuck = 1'b1;
                    n_pc = w_pc_inc;
                end else begin
                    n_addr = w_next_seek;
                    n_cnt  = r_cnt + 1'b1;
                end
                n_res.next_pc = n_pc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tme_pkg::ST_CLEAR;
            r_dp        <= '0;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
            r_mul_en    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dp     <= n_dp;
            r_pc     <= n_pc;
            r_halt   <= n_halt;
            r_clr    <= r_clr + 1'b1;
            r_mul_en <= (r_state == tme_pkg::ST_WAIT_OFF);
            if (r_state == tme_pkg::ST_RESULT) begin
                r_res_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
        if (s_in.valid && s_in.ready) begin
            r_item <= s_in.data;
        end
        if (r_state == tme_pkg::ST_WAIT_OFF) begin
            r_off_val <= i_rd_data;
        end
        // product registered ahead of the add
        if (r_mul_en) begin
            r_prod <= 8'(w_a8 * r_off_val);
        end
    end
endmodule

/* hw/rtl/tape_machine_executor.sv */
// channel | dir | beat payload
// in      | in  | cmd, arg_a, arg_b, in_byte
// out     | out | next_pc, out_valid, out_byte, halted, seek_stuck
// Commands run from accept to result through the tape memory port
// (read, wait, modify-write, result); mac adds an extra read and the
// product. While halted an item goes straight to its result. seek_zero
// reads and then checks each tested cell, up to 32768 cells. After
// reset a clearing pass over all 32768 cells zeroes the tape before the
// first item is taken. The next item is taken once the result beat has left.
module tape_machine_executor (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tme_in_if.sink    s_in,
    tme_out_if.source m_out
);
    tme_pkg::t_tape_req w_req;
    logic [7:0]         w_rd_data;

    tme_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (s_in),
        .m_out     (m_out),
        .o_req     (w_req),
        .i_rd_data (w_rd_data)
    );

    tme_tape u_tape (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );
endmodule
